@@ rtl/assert_macros.svh @@
// assertion macros used by the pacer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold at every clock edge outside reset
`define PRP_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define PRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PRP_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define PRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/prp_pkg.sv @@
// package with widths, codes and types of the packet replay pacer
package prp_pkg;

    // internal time width and speed fixed point format
    localparam int TIME_BITS       = 64;
    localparam int SPEED_FRAC_BITS = 16;
    localparam int SPEED_W         = 32;

    // port field widths
    localparam int IN_TIME_W = 63;
    localparam int WAIT_W    = 63;
    localparam int LEN_W     = 16;
    localparam int CFG_ADDR_W = 1;

    // microseconds per second
    localparam int USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = USEC_W'(1000000);

    // divider sweep: dividend bits plus fraction bits
    localparam int DIV_STEPS = TIME_BITS + SPEED_FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [SPEED_W-1:0]   speed_t;

    localparam speed_t SPEED_ONE = speed_t'(1) << SPEED_FRAC_BITS;
    localparam time_t  TIME_MAX  = {TIME_BITS{1'b1}};
    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SPEED = CFG_ADDR_W'(1);

    // pacing modes
    typedef enum logic [1:0] {
        MODE_TOP       = 2'd0,
        MODE_MULT      = 2'd1,
        MODE_BYTE_RATE = 2'd2,
        MODE_PKT_RATE  = 2'd3
    } mode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_ACCUM,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

@@ rtl/packet_replay_pacer.sv @@
// packet replay pacer: gap computation, owed total and wait calculation
// Usage: one input transfer per packet carries its capture timestamp, the
// previous packet's timestamp (zero marks the first packet of a file), its
// length and the current wall time, times in microseconds. One result transfer
// follows per packet with wait_us and must_wait. Mode and speed are written
// through the cfg port (index 0 mode, index 1 speed in 16.16); the user must
// write them only while idle, as the block does not enforce it. No division
// is done in multiplier mode at speed 0 or 1.0, in rate modes at speed 0 or
// in byte rate mode on a first packet; top speed also skips the owed total
// and wait steps. The gap division by speed is done by one shared restoring
// divide step, one quotient bit per cycle, which sets the packet rate. in_ready
// is high only while the sequencer is idle, from the cycle after a result is
// loaded, so a packet is not taken before the previous result is loaded.
// A finished result sits in the output register; the next packet is taken
// while it waits, and a new result waits in the sequencer until the receiver
// takes the previous one. Reset sets mode 1, speed 1.0 and clears start time
// and owed total; no result is pending after reset.
`include "assert_macros.svh"

module packet_replay_pacer
    import prp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SPEED_W-1:0]    cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [IN_TIME_W-1:0]  packet_time_us,
    input  logic [IN_TIME_W-1:0]  previous_time_us,
    input  logic [LEN_W-1:0]      length,
    input  logic [IN_TIME_W-1:0]  now_us,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WAIT_W-1:0]     wait_us,
    output logic                  must_wait
);

    // control and architectural state
    state_t state_reg, state_next;
    mode_t  mode_reg;
    speed_t speed_reg;
    time_t  start_reg, start_next;
    time_t  owed_reg, owed_next;
    logic   out_valid_reg;

    // packet payload captured at the input transfer
    time_t             pkt_reg;
    time_t             prev_reg;
    logic [LEN_W-1:0]  len_reg;
    time_t             now_reg;

    // working registers
    time_t             elapsed_reg, elapsed_next;
    time_t             dq_reg, dq_next;
    logic [SPEED_W-1:0] rem_reg, rem_next;
    logic              sat_reg, sat_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_div;
    logic [WAIT_W-1:0] res_wait_reg, res_wait_next;
    logic              res_must_reg, res_must_next;
    logic [WAIT_W-1:0] out_wait_reg;
    logic              out_must_reg;

    // handshake, sequencer and divide counter strobes
    logic in_xfer;
    logic out_load;
    logic div_last;

    // datapath intermediates
    logic                    first;
    logic [TIME_BITS:0]      elap_diff;
    logic [TIME_BITS:0]      gap_diff;
    time_t                   gap_raw;
    logic [LEN_W+USEC_W-1:0] byte_prod;
    logic                    div_bit;
    logic [SPEED_W:0]        rem_shift;
    logic [SPEED_W:0]        rem_sub;
    logic                    rem_ge;
    time_t                   gap_final;
    logic [TIME_BITS:0]      owed_sum;
    logic [TIME_BITS:0]      wait_diff;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_MULT;
            speed_reg <= SPEED_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MODE:  mode_reg  <= mode_t'(cfg_wdata[1:0]);
                REG_SPEED: speed_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_PREP;
            ST_PREP:
            begin
                if (mode_reg == MODE_TOP)
                    state_next = ST_DONE;
                else if (do_div)
                    state_next = ST_DIV;
                else
                    state_next = ST_ACCUM;
            end
            ST_DIV:   if (div_last) state_next = ST_ACCUM;
            ST_ACCUM: state_next = ST_CMP;
            ST_CMP:   state_next = ST_DONE;
            ST_DONE:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DONE: out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    assign in_xfer  = in_valid && in_ready;
    assign div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // gap setup: elapsed time, raw timestamp gap and byte product
    assign first     = (prev_reg == '0);
    assign elap_diff = {1'b0, now_reg} - {1'b0, start_reg};
    assign gap_diff  = {1'b0, pkt_reg} - {1'b0, prev_reg};
    assign gap_raw   = (!first && !gap_diff[TIME_BITS]) ? gap_diff[TIME_BITS-1:0] : '0;
    assign byte_prod = len_reg * USEC_PER_SEC;

    always_comb
    begin
        do_div = 1'b0;
        case (mode_reg)
            MODE_MULT:      do_div = (speed_reg != '0) && (speed_reg != SPEED_ONE);
            MODE_BYTE_RATE: do_div = !first && (speed_reg != '0);
            MODE_PKT_RATE:  do_div = (speed_reg != '0);
            default:        do_div = 1'b0;
        endcase
    end

    // shared divide step: dividend leaves dq at the top, quotient enters at the bottom
    assign div_bit   = (cnt_reg < CNT_W'(TIME_BITS)) ? dq_reg[TIME_BITS-1] : 1'b0;
    assign rem_shift = {rem_reg, div_bit};
    assign rem_sub   = rem_shift - {1'b0, speed_reg};
    assign rem_ge    = (rem_shift >= {1'b0, speed_reg});

    // owed total update and wait computation
    assign gap_final = sat_reg ? TIME_MAX : dq_reg;
    assign owed_sum  = {1'b0, owed_reg} + {1'b0, gap_final};
    assign wait_diff = {1'b0, owed_reg} - {1'b0, elapsed_reg};

    // datapath next values
    always_comb
    begin
        start_next    = start_reg;
        owed_next     = owed_reg;
        elapsed_next  = elapsed_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        sat_next      = sat_reg;
        cnt_next      = cnt_reg;
        res_wait_next = res_wait_reg;
        res_must_next = res_must_reg;
        case (state_reg)
            ST_PREP:
            begin
                rem_next      = '0;
                sat_next      = 1'b0;
                cnt_next      = '0;
                res_wait_next = '0;
                res_must_next = 1'b0;
                if (mode_reg != MODE_TOP)
                begin
                    if (first)
                    begin
                        start_next   = now_reg;
                        owed_next    = '0;
                        elapsed_next = '0;
                    end
                    else if (elap_diff[TIME_BITS])
                        elapsed_next = '0;
                    else
                        elapsed_next = elap_diff[TIME_BITS-1:0];
                    case (mode_reg)
                        MODE_MULT:      dq_next = gap_raw;
                        MODE_BYTE_RATE: dq_next = do_div ? time_t'(byte_prod) : '0;
                        MODE_PKT_RATE:  dq_next = do_div ? time_t'(USEC_PER_SEC) : '0;
                        default:        dq_next = '0;
                    endcase
                end
            end
            ST_DIV:
            begin
                // a quotient bit pushed out of the top means overflow
                if (!(cnt_reg < CNT_W'(TIME_BITS)) && dq_reg[TIME_BITS-1])
                    sat_next = 1'b1;
                dq_next  = {dq_reg[TIME_BITS-2:0], rem_ge};
                rem_next = rem_ge ? rem_sub[SPEED_W-1:0] : rem_shift[SPEED_W-1:0];
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_ACCUM:
            begin
                owed_next = owed_sum[TIME_BITS] ? TIME_MAX : owed_sum[TIME_BITS-1:0];
            end
            ST_CMP:
            begin
                if (!wait_diff[TIME_BITS] && (wait_diff[TIME_BITS-1:0] != '0))
                begin
                    res_must_next = 1'b1;
                    res_wait_next = (wait_diff[TIME_BITS-1:0] > time_t'(WAIT_MAX))
                                    ? WAIT_MAX : WAIT_W'(wait_diff[TIME_BITS-1:0]);
                end
            end
            default: ;
        endcase
    end

    // control and pacing state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= '0;
            owed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
            owed_reg  <= owed_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pkt_reg  <= time_t'(packet_time_us);
            prev_reg <= time_t'(previous_time_us);
            len_reg  <= length;
            now_reg  <= time_t'(now_us);
        end
        elapsed_reg  <= elapsed_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        sat_reg      <= sat_next;
        cnt_reg      <= cnt_next;
        res_wait_reg <= res_wait_next;
        res_must_reg <= res_must_next;
        if (out_load)
        begin
            out_wait_reg <= res_wait_reg;
            out_must_reg <= res_must_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign wait_us   = out_wait_reg;
    assign must_wait = out_must_reg;

    // owed total does not shrink when a gap is added
    `PRP_ASSERT_NEXT(a_owed_grows, clk, rst_n, state_reg == ST_ACCUM, owed_reg >= $past(owed_reg))
    // a result without pacing carries a zero wait
    `PRP_ASSERT_ALWAYS(a_zero_wait, clk, rst_n, !out_valid_reg || must_wait || (wait_us == '0))
    // an input transfer starts the sequencer and blocks the next one
    `PRP_ASSERT_NEXT(a_in_starts, clk, rst_n, in_xfer, (state_reg == ST_PREP) && !in_ready)

endmodule
